/* rtl/cp1600_instruction_decoder_defines.svh */
// Assertion macros shared by the instruction decoder RTL.
`ifndef CP1600_INSTRUCTION_DECODER_DEFINES_SVH
`define CP1600_INSTRUCTION_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define CP16_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("decoder assertion failed");
// Checks a property on every rising clock edge, reset included.
`define CP16_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("decoder assertion failed");
`else
`define CP16_ASSERT(lbl, clk, rstn, prop)
`define CP16_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/cp16dec_pkg.sv */
// Types and constants of the CP1600 instruction decoder.
`timescale 1ns / 1ps
package cp16dec_pkg;

  // Opcode masks and match values.
  localparam logic [9:0] MASK_IMM_ANY = 10'h238;
  localparam logic [9:0] MASK_GROUP   = 10'h3c0;
  localparam logic [9:0] MASK_OP_HI   = 10'h3f8;
  localparam logic [9:0] OP_MVOI      = 10'h278;
  localparam logic [9:0] OP_JUMP      = 10'h004;
  localparam logic [9:0] OP_BRANCH    = 10'h200;
  localparam logic [9:0] OP_MVO       = 10'h240;
  localparam logic [9:0] OP_DIRECT    = 10'h200;
  localparam logic [1:0] JMODE_PLAIN  = 2'b11;
  localparam logic [4:0] BCOND_NOPP   = 5'h08;
  localparam logic [4:0] BCOND_ALWAYS = 5'h00;

  // Mnemonic codes, dense in decode-tree order.
  localparam logic [6:0] MN_J      = 7'd4;
  localparam logic [6:0] MN_JSR    = 7'd8;
  localparam logic [6:0] MN_JSRI   = 7'd11;
  localparam logic [6:0] MN_TCI    = 7'd12;
  localparam logic [6:0] MN_INCR   = 7'd15;
  localparam logic [6:0] MN_GSWD   = 7'd20;
  localparam logic [6:0] MN_NOP    = 7'd21;
  localparam logic [6:0] MN_SIN    = 7'd22;
  localparam logic [6:0] MN_RSWD   = 7'd23;
  localparam logic [6:0] MN_SWAP   = 7'd24;
  localparam logic [6:0] MN_TSTR   = 7'd32;
  localparam logic [6:0] MN_JR     = 7'd33;
  localparam logic [6:0] MN_MOVR   = 7'd34;
  localparam logic [6:0] MN_ADDR   = 7'd35;
  localparam logic [6:0] MN_CLRR   = 7'd39;
  localparam logic [6:0] MN_XORR   = 7'd40;
  localparam logic [6:0] MN_B      = 7'd41;
  localparam logic [6:0] MN_NOPP   = 7'd42;
  localparam logic [6:0] MN_BC     = 7'd43;
  localparam logic [6:0] MN_BNC    = 7'd50;
  localparam logic [6:0] MN_BEXT   = 7'd57;
  localparam logic [6:0] MN_MVO    = 7'd58;
  localparam logic [6:0] MN_PSHR   = 7'd59;
  localparam logic [6:0] MN_MVOI   = 7'd60;
  localparam logic [6:0] MN_MVO_AT = 7'd61;
  localparam logic [6:0] MN_MVI    = 7'd62;
  localparam logic [6:0] MN_PULR   = 7'd63;
  localparam logic [6:0] MN_MVII   = 7'd64;
  localparam logic [6:0] MN_MVI_AT = 7'd65;
  localparam logic [6:0] MN_ADD    = 7'd66;

  // Operand kinds.
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_REG  = 3'd1,
    KIND_ADDR = 3'd2,
    KIND_IMM  = 3'd3,
    KIND_TWO  = 3'd4,
    KIND_E    = 3'd5
  } kind_e;

  // One instruction as it arrives.
  typedef struct packed {
    logic [15:0] instr_address;
    logic        double_byte_prefix;
    logic [9:0]  first_word;
    logic [15:0] second_word;
    logic [15:0] third_word;
  } in_item_t;

  // One decoded instruction.
  typedef struct packed {
    logic [6:0]  mnemonic;
    logic [1:0]  word_count;
    logic [2:0]  first_kind;
    logic [15:0] first_value;
    logic [2:0]  second_kind;
    logic [15:0] second_value;
    logic        target_valid;
    logic [15:0] target_address;
  } out_item_t;

  // Middle stage: opcode and second word plus the precomputed addresses, immediate and length.
  typedef struct packed {
    logic [9:0]  first_word;
    logic [15:0] second_word;
    logic [15:0] imm;
    logic [15:0] jump_addr;
    logic [15:0] branch_addr;
    logic [1:0]  word_count;
  } pre_t;

endpackage

/* rtl/cp16dec_stream_if.sv */
// Valid/ready channel carrying one payload item per transfer.
`timescale 1ns / 1ps
interface cp16dec_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/cp16dec_decode.sv */
// Operand and mnemonic decode of one prepared instruction.
`timescale 1ns / 1ps
module cp16dec_decode
  import cp16dec_pkg::*;
(
  input  pre_t      pre_i,
  output out_item_t result_o
);

  logic [3:0]  i1;
  logic [2:0]  i2;
  logic [2:0]  i3;
  logic [4:0]  bcond;
  logic [3:0]  bsel;
  logic [6:0]  grp;
  logic [6:0]  grp_base;
  logic [6:0]  mn;
  kind_e       k1;
  kind_e       k2;
  logic [15:0] v1;
  logic [15:0] v2;
  logic        tv;
  logic [15:0] tgt;

  assign i1    = pre_i.first_word[9:6];
  assign i2    = pre_i.first_word[5:3];
  assign i3    = pre_i.first_word[2:0];
  assign bcond = pre_i.first_word[4:0];
  assign bsel  = pre_i.first_word[3:0];

  // Base mnemonic of the ADD..XOR groups: three codes per group.
  assign grp      = {3'd0, i1} - 7'd11;
  assign grp_base = MN_ADD + (grp << 1) + grp;

  // Decode tree over the opcode fields.
  always_comb begin
    mn  = '0;
    k1  = KIND_NONE;
    k2  = KIND_NONE;
    v1  = '0;
    v2  = '0;
    tv  = 1'b0;
    tgt = '0;
    case (i1)
      4'd0: begin
        if (i2 == 3'd0) begin
          if (i3 < 3'd4) begin
            mn = {4'd0, i3};
          end else if (i3 == 3'd4) begin
            tv  = 1'b1;
            tgt = pre_i.jump_addr;
            if (pre_i.second_word[9:8] == JMODE_PLAIN) begin
              mn = MN_J + {5'd0, pre_i.second_word[1:0]};
              k1 = KIND_ADDR;
              v1 = pre_i.jump_addr;
            end else begin
              mn = MN_JSR + {5'd0, pre_i.second_word[1:0]};
              k1 = KIND_REG;
              v1 = {14'd1, pre_i.second_word[9:8]};
              k2 = KIND_ADDR;
              v2 = pre_i.jump_addr;
            end
          end else begin
            mn = MN_TCI + {4'd0, i3} - 7'd5;
          end
        end else if (i2 <= 3'd5) begin
          mn = MN_INCR + {4'd0, i2} - 7'd1;
          k1 = KIND_REG;
          v1 = {13'd0, i3};
        end else if (i2 == 3'd6) begin
          if (!i3[2]) begin
            mn = MN_GSWD;
            k1 = KIND_REG;
            v1 = {14'd0, i3[1:0]};
          end else begin
            mn = i3[1] ? MN_SIN : MN_NOP;
            if (i3[0]) k1 = KIND_TWO;
          end
        end else begin
          mn = MN_RSWD;
          k1 = KIND_REG;
          v1 = {13'd0, i3};
        end
      end
      4'd1: begin
        mn = MN_SWAP + {4'd0, i2};
        k1 = KIND_REG;
        v1 = {14'd0, i3[1:0]};
        if (i3[2]) k2 = KIND_TWO;
      end
      4'd2: begin
        k1 = KIND_REG;
        v1 = {13'd0, i2};
        if (i2 == i3) begin
          mn = MN_TSTR;
        end else if (i3 == 3'd7) begin
          mn = MN_JR;
        end else begin
          mn = MN_MOVR;
          k2 = KIND_REG;
          v2 = {13'd0, i3};
        end
      end
      4'd3, 4'd4, 4'd5, 4'd6: begin
        mn = MN_ADDR + {3'd0, i1} - 7'd3;
        k1 = KIND_REG;
        v1 = {13'd0, i2};
        k2 = KIND_REG;
        v2 = {13'd0, i3};
      end
      4'd7: begin
        k1 = KIND_REG;
        if (i2 == i3) begin
          mn = MN_CLRR;
          v1 = {13'd0, i3};
        end else begin
          mn = MN_XORR;
          v1 = {13'd0, i2};
          k2 = KIND_REG;
          v2 = {13'd0, i3};
        end
      end
      4'd8: begin
        if (bcond == BCOND_NOPP) begin
          mn = MN_NOPP;
        end else begin
          tv  = 1'b1;
          tgt = pre_i.branch_addr;
          k1  = KIND_ADDR;
          v1  = pre_i.branch_addr;
          if (bcond == BCOND_ALWAYS) begin
            mn = MN_B;
          end else if (!bcond[4]) begin
            // Plain conditions first, then their negated forms.
            if (!bsel[3]) mn = MN_BC + {4'd0, bsel[2:0]} - 7'd1;
            else          mn = MN_BNC + {3'd0, bsel} - 7'd9;
          end else begin
            mn = MN_BEXT;
            k2 = KIND_E;
          end
        end
      end
      4'd9: begin
        k1 = KIND_REG;
        v1 = {13'd0, i3};
        if (i2 == 3'd0) begin
          mn = MN_MVO;
          k2 = KIND_ADDR;
          v2 = pre_i.second_word;
        end else if (i2 == 3'd6) begin
          mn = MN_PSHR;
        end else if (i2 == 3'd7) begin
          mn = MN_MVOI;
          k2 = KIND_IMM;
          v2 = pre_i.imm;
        end else begin
          mn = MN_MVO_AT;
          k2 = KIND_REG;
          v2 = {13'd0, i2};
        end
      end
      4'd10: begin
        if (i2 == 3'd6) begin
          mn = MN_PULR;
          k1 = KIND_REG;
          v1 = {13'd0, i3};
        end else begin
          k2 = KIND_REG;
          v2 = {13'd0, i3};
          if (i2 == 3'd0) begin
            mn = MN_MVI;
            k1 = KIND_ADDR;
            v1 = pre_i.second_word;
          end else if (i2 == 3'd7) begin
            mn = MN_MVII;
            k1 = KIND_IMM;
            v1 = pre_i.imm;
          end else begin
            mn = MN_MVI_AT;
            k1 = KIND_REG;
            v1 = {13'd0, i2};
          end
        end
      end
      default: begin
        k2 = KIND_REG;
        v2 = {13'd0, i3};
        if (i2 == 3'd0) begin
          mn = grp_base;
          k1 = KIND_ADDR;
          v1 = pre_i.second_word;
        end else if (i2 == 3'd7) begin
          mn = grp_base + 7'd1;
          k1 = KIND_IMM;
          v1 = pre_i.imm;
        end else begin
          mn = grp_base + 7'd2;
          k1 = KIND_REG;
          v1 = {13'd0, i2};
        end
      end
    endcase
  end

  assign result_o.mnemonic       = mn;
  assign result_o.word_count     = pre_i.word_count;
  assign result_o.first_kind     = k1;
  assign result_o.first_value    = v1;
  assign result_o.second_kind    = k2;
  assign result_o.second_value   = v2;
  assign result_o.target_valid   = tv;
  assign result_o.target_address = tgt;

endmodule

/* rtl/cp1600_instruction_decoder.sv */
// CP1600 instruction decoder: three register stages, one instruction per cycle.
// The result passes through all three register stages before it shows valid.
// Throughput: one instruction per cycle unless the output stalls; stages are input capture, target and
// immediate arithmetic, and operand decode into the output register.
// A stalled output holds its stage; upstream stages keep filling any bubble.
// Reset clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "cp1600_instruction_decoder_defines.svh"
module cp1600_instruction_decoder
  import cp16dec_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  cp16dec_stream_if.sink     item_i,
  cp16dec_stream_if.source   result_o
);

  logic      s1_valid_q, s2_valid_q, s3_valid_q;
  logic      s1_ready, s2_ready, s3_ready;
  in_item_t  s1_q;
  pre_t      s2_d, s2_q;
  out_item_t s3_d, s3_q;
  logic      s3_flow_mn;

  // A stage can load when it is empty or its content moves on.
  assign s3_ready     = !s3_valid_q || result_o.ready;
  assign s2_ready     = !s2_valid_q || s3_ready;
  assign s1_ready     = !s1_valid_q || s2_ready;
  assign item_i.ready = s1_ready;

  // Word count from the opcode class.
  function automatic logic [1:0] length_of(logic [9:0] op, logic dbd);
    logic [1:0] len;
    if (op == OP_JUMP)                        len = 2'd3;
    else if ((op & MASK_GROUP) == OP_BRANCH)  len = 2'd2;
    else if ((op & MASK_OP_HI) == OP_MVO)     len = 2'd2;
    else if ((op & MASK_OP_HI) == OP_MVOI)    len = 2'd2;
    else if ((op & MASK_IMM_ANY) == OP_DIRECT) len = 2'd2;
    else if ((op & MASK_IMM_ANY) == MASK_IMM_ANY) len = {1'b1, dbd};
    else                                      len = 2'd1;
    return len;
  endfunction

  // Stage two: jump and branch targets, immediate assembly and length.
  always_comb begin
    s2_d.first_word  = s1_q.first_word;
    s2_d.second_word = s1_q.second_word;
    s2_d.imm         = s1_q.double_byte_prefix
                       ? {s1_q.third_word[7:0], s1_q.second_word[7:0]}
                       : s1_q.second_word;
    s2_d.jump_addr   = {s1_q.second_word[7:2], s1_q.third_word[9:0]};
    // Displacement sign is opcode bit 5.
    s2_d.branch_addr = s1_q.first_word[5]
                       ? s1_q.instr_address + 16'd1 - s1_q.second_word
                       : s1_q.instr_address + 16'd2 + s1_q.second_word;
    s2_d.word_count  = length_of(s1_q.first_word, s1_q.double_byte_prefix);
  end

  // Stage three: operand decode.
  cp16dec_decode u_decode (
    .pre_i    (s2_q),
    .result_o (s3_d)
  );

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= item_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Stage payloads load only with a valid item behind them.
  always_ff @(posedge clk_i) begin
    if (s1_ready && item_i.valid) s1_q <= item_i.payload;
    if (s2_ready && s1_valid_q)   s2_q <= s2_d;
    if (s3_ready && s2_valid_q)   s3_q <= s3_d;
  end

  assign result_o.valid   = s3_valid_q;
  assign result_o.payload = s3_q;

  // Mnemonics of jumps and taken-form branches.
  assign s3_flow_mn = (s3_q.mnemonic >= MN_J && s3_q.mnemonic <= MN_JSRI) ||
                      (s3_q.mnemonic == MN_B) ||
                      (s3_q.mnemonic >= MN_BC && s3_q.mnemonic <= MN_BEXT);

  // A blocked first stage keeps its item unchanged.
  `CP16_ASSERT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_q))
  // Only jumps and taken-form branches carry a target.
  `CP16_ASSERT(a_target_mn, clk_i, rst_ni, s3_valid_q && s3_q.target_valid |-> s3_flow_mn)
  // Every result has a nonzero length.
  `CP16_ASSERT(a_len_nonzero, clk_i, rst_ni, s3_valid_q |-> s3_q.word_count != 2'd0)
  // Reset leaves the pipeline empty on the next edge.
  `CP16_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !s1_valid_q && !s2_valid_q && !s3_valid_q)

endmodule

/* verif/tb_cp1600_instruction_decoder.sv */
// Self-checking testbench for the CP1600 instruction decoder with its own decode predictor.
`timescale 1ns / 1ps
module tb_cp1600_instruction_decoder
  import cp16dec_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Mnemonic codes and field values that the package does not name.
  localparam logic [6:0] MN_HLT        = 7'd0;
  localparam logic [6:0] MN_FAMILY_LEN = 7'd3;
  localparam logic [6:0] MN_FORM_IMM   = 7'd1;
  localparam logic [6:0] MN_FORM_AT    = 7'd2;
  localparam logic [3:0] GRP_IMPLIED   = 4'd0;
  localparam logic [3:0] GRP_ROTATE    = 4'd1;
  localparam logic [3:0] GRP_MOVR      = 4'd2;
  localparam logic [3:0] GRP_ADDR      = 4'd3;
  localparam logic [3:0] GRP_XORR      = 4'd7;
  localparam logic [3:0] GRP_BRANCH    = 4'd8;
  localparam logic [3:0] GRP_STORE     = 4'd9;
  localparam logic [3:0] GRP_LOAD      = 4'd10;
  localparam logic [3:0] GRP_ADD       = 4'd11;
  localparam logic [2:0] MODE_DIRECT   = 3'd0;
  localparam logic [2:0] MODE_STACK    = 3'd6;
  localparam logic [2:0] MODE_IMMED    = 3'd7;
  localparam logic [2:0] SUB_JUMP      = 3'd4;
  localparam logic [2:0] SUB_GSWD_END  = 3'd4;
  localparam logic [2:0] SUB_TCI       = 3'd5;
  localparam logic [2:0] SUB_SIN       = 3'd6;
  localparam logic [2:0] REG_PC        = 3'd7;
  localparam logic [15:0] REG_LINK_BASE = 16'd4;

  logic clk_i = 1'b0;
  logic rst_ni;

  cp16dec_stream_if #(.payload_t(in_item_t))  item_if ();
  cp16dec_stream_if #(.payload_t(out_item_t)) result_if ();

  cp1600_instruction_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  always #2 clk_i = ~clk_i;

  out_item_t   decoded_q[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Sender idling: bursts of random length separated by random gaps.
  int unsigned gap_max = 0;
  int unsigned burst_max = 1;
  int unsigned burst_left = 0;

  // Receiver idling: runs of ready or stall, plus an optional long hold-off.
  int unsigned stall_pct = 0;
  int unsigned run_max = 0;
  int unsigned ready_run_left = 0;
  int unsigned hold_off_left = 0;

  // Decode of one instruction as the block is expected to produce it.
  function automatic out_item_t decode_instr(input in_item_t it);
    out_item_t   r;
    logic [3:0]  grp;
    logic [2:0]  fld_a;
    logic [2:0]  fld_b;
    logic [4:0]  cond;
    logic [15:0] imm;
    logic [15:0] jump_dest;
    logic [15:0] branch_dest;
    logic [6:0]  base;
    r = '0;
    grp = it.first_word[9:6];
    fld_a = it.first_word[5:3];
    fld_b = it.first_word[2:0];
    cond = it.first_word[4:0];
    imm = it.double_byte_prefix ? {it.third_word[7:0], it.second_word[7:0]}
                                : it.second_word;
    jump_dest = {it.second_word[7:2], it.third_word[9:0]};
    branch_dest = it.first_word[5] ? it.instr_address + 16'd1 - it.second_word
                                   : it.instr_address + 16'd2 + it.second_word;

    // Instruction length.
    if (it.first_word == OP_JUMP) r.word_count = 2'd3;
    else if ((it.first_word & MASK_GROUP) == OP_BRANCH) r.word_count = 2'd2;
    else if ((it.first_word & MASK_OP_HI) == OP_MVO) r.word_count = 2'd2;
    else if ((it.first_word & MASK_OP_HI) == OP_MVOI) r.word_count = 2'd2;
    else if ((it.first_word & MASK_IMM_ANY) == OP_DIRECT) r.word_count = 2'd2;
    else if ((it.first_word & MASK_IMM_ANY) == MASK_IMM_ANY)
      r.word_count = {1'b1, it.double_byte_prefix};
    else r.word_count = 2'd1;

    // Mnemonic and operands by opcode group.
    case (grp)
      GRP_IMPLIED: begin
        if (fld_a == 3'd0) begin
          if (fld_b < SUB_JUMP) begin
            r.mnemonic = MN_HLT + {4'd0, fld_b};
          end else if (fld_b == SUB_JUMP) begin
            r.target_valid = 1'b1;
            r.target_address = jump_dest;
            if (it.second_word[9:8] == JMODE_PLAIN) begin
              r.mnemonic = MN_J + {5'd0, it.second_word[1:0]};
              r.first_kind = KIND_ADDR;
              r.first_value = jump_dest;
            end else begin
              r.mnemonic = MN_JSR + {5'd0, it.second_word[1:0]};
              r.first_kind = KIND_REG;
              r.first_value = REG_LINK_BASE + {14'd0, it.second_word[9:8]};
              r.second_kind = KIND_ADDR;
              r.second_value = jump_dest;
            end
          end else begin
            r.mnemonic = MN_TCI + {4'd0, fld_b - SUB_TCI};
          end
        end else if (fld_a < MODE_STACK) begin
          r.mnemonic = MN_INCR + {4'd0, fld_a - 3'd1};
          r.first_kind = KIND_REG;
          r.first_value = {13'd0, fld_b};
        end else if (fld_a == MODE_STACK) begin
          if (fld_b < SUB_GSWD_END) begin
            r.mnemonic = MN_GSWD;
            r.first_kind = KIND_REG;
            r.first_value = {14'd0, fld_b[1:0]};
          end else begin
            r.mnemonic = (fld_b < SUB_SIN) ? MN_NOP : MN_SIN;
            if (fld_b[0]) r.first_kind = KIND_TWO;
          end
        end else begin
          r.mnemonic = MN_RSWD;
          r.first_kind = KIND_REG;
          r.first_value = {13'd0, fld_b};
        end
      end
      GRP_ROTATE: begin
        r.mnemonic = MN_SWAP + {4'd0, fld_a};
        r.first_kind = KIND_REG;
        r.first_value = {14'd0, fld_b[1:0]};
        if (fld_b[2]) r.second_kind = KIND_TWO;
      end
      GRP_MOVR: begin
        r.first_kind = KIND_REG;
        r.first_value = {13'd0, fld_a};
        if (fld_a == fld_b) begin
          r.mnemonic = MN_TSTR;
        end else if (fld_b == REG_PC) begin
          r.mnemonic = MN_JR;
        end else begin
          r.mnemonic = MN_MOVR;
          r.second_kind = KIND_REG;
          r.second_value = {13'd0, fld_b};
        end
      end
      GRP_XORR: begin
        r.first_kind = KIND_REG;
        if (fld_a == fld_b) begin
          r.mnemonic = MN_CLRR;
          r.first_value = {13'd0, fld_b};
        end else begin
          r.mnemonic = MN_XORR;
          r.first_value = {13'd0, fld_a};
          r.second_kind = KIND_REG;
          r.second_value = {13'd0, fld_b};
        end
      end
      GRP_BRANCH: begin
        if (cond == BCOND_NOPP) begin
          r.mnemonic = MN_NOPP;
        end else begin
          r.target_valid = 1'b1;
          r.target_address = branch_dest;
          r.first_kind = KIND_ADDR;
          r.first_value = branch_dest;
          if (cond == BCOND_ALWAYS) r.mnemonic = MN_B;
          else if (!cond[4] && !cond[3]) r.mnemonic = MN_BC + {3'd0, cond[3:0] - 4'd1};
          else if (!cond[4]) r.mnemonic = MN_BNC + {3'd0, cond[3:0] - 4'd9};
          else begin
            r.mnemonic = MN_BEXT;
            r.second_kind = KIND_E;
          end
        end
      end
      GRP_STORE: begin
        r.first_kind = KIND_REG;
        r.first_value = {13'd0, fld_b};
        if (fld_a == MODE_DIRECT) begin
          r.mnemonic = MN_MVO;
          r.second_kind = KIND_ADDR;
          r.second_value = it.second_word;
        end else if (fld_a == MODE_STACK) begin
          r.mnemonic = MN_PSHR;
        end else if (fld_a == MODE_IMMED) begin
          r.mnemonic = MN_MVOI;
          r.second_kind = KIND_IMM;
          r.second_value = imm;
        end else begin
          r.mnemonic = MN_MVO_AT;
          r.second_kind = KIND_REG;
          r.second_value = {13'd0, fld_a};
        end
      end
      GRP_LOAD: begin
        if (fld_a == MODE_STACK) begin
          r.mnemonic = MN_PULR;
          r.first_kind = KIND_REG;
          r.first_value = {13'd0, fld_b};
        end else begin
          r.second_kind = KIND_REG;
          r.second_value = {13'd0, fld_b};
          if (fld_a == MODE_DIRECT) begin
            r.mnemonic = MN_MVI;
            r.first_kind = KIND_ADDR;
            r.first_value = it.second_word;
          end else if (fld_a == MODE_IMMED) begin
            r.mnemonic = MN_MVII;
            r.first_kind = KIND_IMM;
            r.first_value = imm;
          end else begin
            r.mnemonic = MN_MVI_AT;
            r.first_kind = KIND_REG;
            r.first_value = {13'd0, fld_a};
          end
        end
      end
      default: begin
        if (grp >= GRP_ADD) begin
          base = MN_ADD + MN_FAMILY_LEN * {3'd0, grp - GRP_ADD};
          r.second_kind = KIND_REG;
          r.second_value = {13'd0, fld_b};
          if (fld_a == MODE_DIRECT) begin
            r.mnemonic = base;
            r.first_kind = KIND_ADDR;
            r.first_value = it.second_word;
          end else if (fld_a == MODE_IMMED) begin
            r.mnemonic = base + MN_FORM_IMM;
            r.first_kind = KIND_IMM;
            r.first_value = imm;
          end else begin
            r.mnemonic = base + MN_FORM_AT;
            r.first_kind = KIND_REG;
            r.first_value = {13'd0, fld_a};
          end
        end else begin
          // Register-to-register arithmetic, ADDR through ANDR.
          r.mnemonic = MN_ADDR + {3'd0, grp - GRP_ADDR};
          r.first_kind = KIND_REG;
          r.first_value = {13'd0, fld_a};
          r.second_kind = KIND_REG;
          r.second_value = {13'd0, fld_b};
        end
      end
    endcase
    return r;
  endfunction

  function automatic string fmt_decode(input out_item_t d);
    return $sformatf("mn=%0d len=%0d k1=%0d v1=%h k2=%0d v2=%h tv=%0d tgt=%h",
                     d.mnemonic, d.word_count, d.first_kind, d.first_value,
                     d.second_kind, d.second_value, d.target_valid, d.target_address);
  endfunction

  function automatic in_item_t make_instr(input logic [15:0] addr, input logic dbd,
                                          input logic [9:0] w1, input logic [15:0] w2,
                                          input logic [15:0] w3);
    in_item_t it;
    it.instr_address = addr;
    it.double_byte_prefix = dbd;
    it.first_word = w1;
    it.second_word = w2;
    it.third_word = w3;
    return it;
  endfunction

  // Word with extra weight on the all-zero and all-one values.
  function automatic logic [15:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hffff;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Random instruction; flow_pct biases toward jumps and branches.
  function automatic in_item_t rand_instr(input int unsigned flow_pct);
    in_item_t it;
    it.instr_address = rand_word();
    it.double_byte_prefix = 1'($urandom_range(0, 1));
    it.second_word = rand_word();
    it.third_word = rand_word();
    if ($urandom_range(0, 99) < flow_pct) begin
      if ($urandom_range(0, 1) == 0) it.first_word = OP_JUMP;
      else it.first_word = OP_BRANCH | 10'($urandom_range(0, 63));
    end else begin
      it.first_word = 10'($urandom_range(0, 1023));
    end
    return it;
  endfunction

  // Offers one instruction and waits for its transfer. Called at a falling edge.
  task automatic send_instr(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    item_if.valid <= 1'b1;
    item_if.payload <= it;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    decoded_q.push_back(decode_instr(it));
    @(negedge clk_i);
  endtask

  // Receiver ready pattern, driven at the falling edge; held low in reset.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_left != 0) begin
        result_if.ready <= 1'b0;
        hold_off_left--;
        ready_run_left = 0;
      end else if (ready_run_left != 0) begin
        ready_run_left--;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        ready_run_left = $urandom_range(0, run_max);
      end
    end else begin
      result_if.ready <= 1'b0;
    end
  end

  // Each result transfer is checked against the oldest pending decode.
  out_item_t want;
  out_item_t got;
  string     diffs;

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (decoded_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("Unexpected result with nothing pending: %s", fmt_decode(got));
      end else begin
        want = decoded_q.pop_front();
        diffs = "";
        if (got.mnemonic !== want.mnemonic) diffs = {diffs, " mnemonic"};
        if (got.word_count !== want.word_count) diffs = {diffs, " word_count"};
        if (got.first_kind !== want.first_kind) diffs = {diffs, " first_kind"};
        if (got.first_value !== want.first_value) diffs = {diffs, " first_value"};
        if (got.second_kind !== want.second_kind) diffs = {diffs, " second_kind"};
        if (got.second_value !== want.second_value) diffs = {diffs, " second_value"};
        if (got.target_valid !== want.target_valid) diffs = {diffs, " target_valid"};
        if (got.target_address !== want.target_address) diffs = {diffs, " target_address"};
        if (diffs != "") begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("Decode mismatch on%s\n  expected %s\n  actual   %s",
                     diffs, fmt_decode(want), fmt_decode(got));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hand-picked opcodes at full rate: a selection of special cases and field extremes.
  task automatic test_directed_opcodes();
    gap_max = 0;
    stall_pct = 0;
    run_max = 0;
    send_instr(make_instr(16'h0000, 1'b0, 10'h000, 16'h0000, 16'h0000));
    send_instr(make_instr(16'hffff, 1'b1, 10'h001, 16'hffff, 16'hffff));
    send_instr(make_instr(16'h1234, 1'b0, 10'h004, 16'h03ff, 16'h03ff));
    send_instr(make_instr(16'h5000, 1'b0, 10'h004, 16'h0300, 16'h0000));
    send_instr(make_instr(16'h0000, 1'b0, 10'h004, 16'h00fc, 16'hffff));
    send_instr(make_instr(16'h8000, 1'b1, 10'h004, 16'h0202, 16'h0155));
    send_instr(make_instr(16'h0100, 1'b0, 10'h035, 16'h0000, 16'h0000));
    send_instr(make_instr(16'h0100, 1'b0, 10'h036, 16'h0000, 16'h0000));
    send_instr(make_instr(16'h0100, 1'b0, 10'h076, 16'h0000, 16'h0000));
    send_instr(make_instr(16'h0100, 1'b0, 10'h0bf, 16'h0000, 16'h0000));
    send_instr(make_instr(16'h0100, 1'b0, 10'h0b7, 16'h0000, 16'h0000));
    send_instr(make_instr(16'h0100, 1'b0, 10'h081, 16'h0000, 16'h0000));
    send_instr(make_instr(16'h0100, 1'b0, 10'h1ff, 16'h0000, 16'h0000));
    send_instr(make_instr(16'h0100, 1'b0, 10'h1c7, 16'h0000, 16'h0000));
    // Branch offsets that wrap past the top and bottom of memory.
    send_instr(make_instr(16'hffff, 1'b0, 10'h200, 16'hffff, 16'h0000));
    send_instr(make_instr(16'h0000, 1'b0, 10'h220, 16'hffff, 16'h0000));
    send_instr(make_instr(16'h4000, 1'b0, 10'h208, 16'h0010, 16'h0000));
    send_instr(make_instr(16'h4000, 1'b0, 10'h21f, 16'h0010, 16'h0000));
    send_instr(make_instr(16'h4000, 1'b0, 10'h209, 16'h0003, 16'h0000));
    send_instr(make_instr(16'h0200, 1'b0, 10'h240, 16'hbeef, 16'h0000));
    // Immediates built from two bytes under the double-byte prefix.
    send_instr(make_instr(16'h0200, 1'b1, 10'h278, 16'h12ab, 16'hcd34));
    send_instr(make_instr(16'h0200, 1'b0, 10'h2b7, 16'h0000, 16'h0000));
    send_instr(make_instr(16'h0200, 1'b0, 10'h2bf, 16'hffff, 16'h00ff));
    send_instr(make_instr(16'h0200, 1'b1, 10'h2f8, 16'hff00, 16'h00ff));
    send_instr(make_instr(16'hffff, 1'b1, 10'h3ff, 16'hffff, 16'hffff));
  endtask

  // Random opcodes with idling on both sides.
  task automatic test_random_idling();
    gap_max = 6;
    burst_max = 12;
    stall_pct = 40;
    run_max = 5;
    repeat (700) send_instr(rand_instr(20));
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall its input.
  task automatic test_output_holdoff();
    gap_max = 0;
    stall_pct = 0;
    run_max = 0;
    hold_off_left = 400;
    repeat (120) send_instr(rand_instr(20));
  endtask

  // Mostly jumps and branches at full rate.
  task automatic test_flow_targets();
    gap_max = 0;
    stall_pct = 0;
    run_max = 0;
    repeat (200) send_instr(rand_instr(70));
  endtask

  // Random opcodes with a light receiver stall and no sender gaps.
  task automatic test_random_light_stall();
    gap_max = 0;
    stall_pct = 15;
    run_max = 2;
    repeat (100) send_instr(rand_instr(20));
  endtask

  initial begin
    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.payload = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_opcodes();
    test_random_idling();
    test_output_holdoff();
    test_flow_targets();
    test_random_light_stall();

    // Drain the pipeline; the receiver stall chance is set to zero.
    item_if.valid <= 1'b0;
    stall_pct = 0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
